>>> src/phc_pkg.sv
package phc_pkg;

  localparam int CORDIC_ITERS = 16;
  localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032875;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_WEIGHT   = 3'd1,
    REG_EXPONENT = 3'd2,
    REG_STRIDE   = 3'd3,
    REG_PENALTY  = 3'd4
  } phc_reg_t;

  // classified item as it travels from front to back
  typedef struct packed {
    logic        is_sample;
    logic        store_ok;
    logic        scored;
    logic        invalid;
    logic        last;
    logic [15:0] heading;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
  } phc_item_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DISP, B_SCAN, B_RD_B, B_RD_E, B_SEG, B_NORM, B_VEC,
    B_CINIT, B_COS, B_ACC, B_TAIL, B_DIV, B_WEIGHT, B_POW, B_EMIT
  } phc_state_t;

  // cordic angle table in 16-bit turns
  function automatic logic [15:0] phc_angle(input logic [3:0] i);
    logic [15:0] a;
    case (i)
      4'd0:  a = 16'd8192;
      4'd1:  a = 16'd4836;
      4'd2:  a = 16'd2555;
      4'd3:  a = 16'd1297;
      4'd4:  a = 16'd651;
      4'd5:  a = 16'd326;
      4'd6:  a = 16'd163;
      4'd7:  a = 16'd81;
      4'd8:  a = 16'd41;
      4'd9:  a = 16'd20;
      4'd10: a = 16'd10;
      4'd11: a = 16'd5;
      4'd12: a = 16'd3;
      4'd13: a = 16'd1;
      4'd14: a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

>>> src/phc_queue.sv
module phc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic [1:0]       wp;
  logic [1:0]       rp;

  assign full  = (wp[1] != rp[1]) && (wp[0] == rp[0]);
  assign empty = (wp == rp);
  assign rdata = slot[rp[0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 2'd0;
      rp <= 2'd0;
    end else begin
      if (push && !full) begin
        wp <= wp + 2'd1;
      end
      if (pop && !empty) begin
        rp <= rp + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wp[0]] <= wdata;
    end
  end

endmodule

>>> src/phc_front.sv
module phc_front #(
  parameter int MAX_PATH_POINTS = 256,
  localparam int CW = $clog2(MAX_PATH_POINTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                q_full,
  input  logic                action,
  input  logic                first_point,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic [15:0]         heading,
  input  logic                sample_invalid,
  input  logic                last_sample,
  input  logic                enable,
  input  logic [7:0]          sample_stride,
  output logic                push,
  output phc_pkg::phc_item_t  item,
  output logic [CW-1:0]       item_cnt
);
  import phc_pkg::*;

  logic [CW-1:0] path_count;
  logic [7:0]    step_phase;
  logic [CW-1:0] cnt_base;
  logic          store_ok;
  logic [8:0]    stride_eff;
  logic [8:0]    phase_inc;

  assign push       = start && !q_full;
  assign cnt_base   = first_point ? '0 : path_count;
  assign store_ok   = cnt_base < CW'(MAX_PATH_POINTS);
  assign stride_eff = (sample_stride == 8'd0) ? 9'd1 : {1'b0, sample_stride};
  assign phase_inc  = {1'b0, step_phase} + 9'd1;

  always_comb begin
    item.is_sample = action;
    item.store_ok  = store_ok;
    item.scored    = enable && (path_count >= CW'(2)) && (step_phase == 8'd0);
    item.invalid   = sample_invalid;
    item.last      = last_sample;
    item.heading   = heading;
    item.pos_x     = pos_x;
    item.pos_y     = pos_y;
    item_cnt       = action ? path_count : cnt_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_count <= '0;
      step_phase <= 8'd0;
    end else if (push) begin
      if (!action) begin
        path_count <= store_ok ? cnt_base + CW'(1) : cnt_base;
      end else if (last_sample || phase_inc >= stride_eff) begin
        step_phase <= 8'd0;
      end else begin
        step_phase <= phase_inc[7:0];
      end
    end
  end

endmodule

>>> src/phc_back.sv
module phc_back #(
  parameter int MAX_PATH_POINTS = 256,
  parameter int MAX_TIME_STEPS = 65535,
  localparam int CW = $clog2(MAX_PATH_POINTS + 1),
  localparam int AW = $clog2(MAX_PATH_POINTS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_pop,
  input  phc_pkg::phc_item_t item,
  input  logic [CW-1:0]      item_cnt,
  input  logic               enable,
  input  logic [15:0]        mean_weight,
  input  logic [2:0]         cost_exponent,
  input  logic [31:0]        invalid_penalty,
  output logic               done,
  output logic [31:0]        trajectory_cost,
  output logic               path_too_short
);
  import phc_pkg::*;

  phc_state_t state, state_next;

  phc_item_t     cur;
  logic [CW-1:0] cur_cnt;

  logic [31:0] mem_x [MAX_PATH_POINTS];
  logic [31:0] mem_y [MAX_PATH_POINTS];
  logic [15:0] mem_h [MAX_PATH_POINTS];
  logic [AW-1:0] rd_addr;
  logic [31:0] rd_x, rd_y;
  logic [15:0] rd_h;

  // nearest point scan pipeline
  logic [CW-1:0] scan_i;
  logic          issue, scan_done;
  logic          v1, v2, v3;
  logic [AW-1:0] idx1, idx2, idx3;
  logic [31:0]   ax, ay;
  logic [63:0]   sqx, sqy;
  logic [AW-1:0] best_idx;
  logic [64:0]   best_d;
  logic [32:0]   dpx, dpy;
  logic [31:0]   abs_x, abs_y;
  logic [64:0]   dist_sum;

  // segment and angle
  logic [CW-1:0] nxt_idx;
  logic          mid;
  logic [AW-1:0] b_idx, e_idx;
  logic [31:0]   bx, by;
  logic [15:0]   bh;
  logic signed [32:0] seg_dx, seg_dy;
  logic signed [43:0] vx, vy, shvx, shvy;
  logic          vx_small, vy_small;
  logic [15:0]   z;
  logic [3:0]    iter;
  logic [15:0]   tab;

  // cosine
  logic [15:0]        err;
  logic signed [33:0] cx, cy, shcx, shcy, crnd;
  logic signed [17:0] cr;
  logic               cneg;
  logic signed [18:0] cval, cosv, cost_s;
  logic [32:0]        sum_ext;

  // accumulators and final stage
  logic [31:0] cost_sum;
  logic [15:0] scored_count;
  logic        broken;
  logic [15:0] div_rem;
  logic [31:0] div_q;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [4:0]  div_cnt;
  logic [47:0] wprod;
  logic [31:0] base, acc, base_sat, pow_sat;
  logic [63:0] pprod;
  logic [2:0]  pk, pexp;

  // ---- combinational datapath ----
  assign issue     = (state == B_SCAN) && (scan_i < cur_cnt);
  assign scan_done = (scan_i == cur_cnt) && !v1 && !v2 && !v3;
  assign dpx   = {cur.pos_x[31], cur.pos_x} - {rd_x[31], rd_x};
  assign dpy   = {cur.pos_y[31], cur.pos_y} - {rd_y[31], rd_y};
  assign abs_x = dpx[32] ? 32'(-dpx) : dpx[31:0];
  assign abs_y = dpy[32] ? 32'(-dpy) : dpy[31:0];
  assign dist_sum = {1'b0, sqx} + {1'b0, sqy};

  assign nxt_idx = CW'(best_idx) + CW'(1);
  assign mid     = nxt_idx < cur_cnt;
  assign b_idx   = mid ? best_idx : best_idx - AW'(1);
  assign e_idx   = mid ? best_idx + AW'(1) : best_idx;
  assign seg_dx  = $signed({rd_x[31], rd_x}) - $signed({bx[31], bx});
  assign seg_dy  = $signed({rd_y[31], rd_y}) - $signed({by[31], by});

  assign vx_small = (vx < 44'sd549755813888) && (vx > -44'sd549755813888);
  assign vy_small = (vy < 44'sd549755813888) && (vy > -44'sd549755813888);
  assign shvx = vx >>> iter;
  assign shvy = vy >>> iter;
  assign tab  = phc_angle(iter);

  assign err  = cur.heading - z;
  assign shcx = cx >>> iter;
  assign shcy = cy >>> iter;
  assign crnd = (cx + 34'sd16384) >>> 15;

  always_comb begin
    if (crnd > 34'sd32768) begin
      cval = 19'sd32768;
    end else if (crnd < -34'sd32768) begin
      cval = -19'sd32768;
    end else begin
      cval = crnd[18:0];
    end
    cosv   = cneg ? -cval : cval;
    cost_s = 19'sd32768 - cosv;
  end

  assign sum_ext = {1'b0, cost_sum} + 33'(cost_s[16:0]);
  assign rem_sh  = {div_rem, div_q[31]};
  assign rem_ge  = rem_sh >= {1'b0, scored_count};
  assign wprod   = mean_weight * div_q;
  assign base_sat = (|wprod[47:39]) ? 32'hFFFF_FFFF : wprod[38:7];
  assign pprod   = acc * base;
  assign pow_sat = (|pprod[63:48]) ? 32'hFFFF_FFFF : pprod[47:16];
  assign pexp    = (cost_exponent == 3'd0) ? 3'd1 : cost_exponent;

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!q_empty) state_next = B_DISP;
      B_DISP: begin
        if (!cur.is_sample) begin
          state_next = B_IDLE;
        end else if (cur.scored && !broken && !cur.invalid) begin
          state_next = B_SCAN;
        end else begin
          state_next = cur.last ? B_TAIL : B_IDLE;
        end
      end
      B_SCAN:  if (scan_done) state_next = B_RD_B;
      B_RD_B:  state_next = B_RD_E;
      B_RD_E:  state_next = B_SEG;
      B_SEG:   state_next = (seg_dx == 33'sd0 && seg_dy == 33'sd0) ? B_CINIT : B_NORM;
      B_NORM:  if (!(vx_small && vy_small)) state_next = B_VEC;
      B_VEC:   if (iter == 4'(CORDIC_ITERS - 1)) state_next = B_CINIT;
      B_CINIT: state_next = B_COS;
      B_COS:   if (iter == 4'(CORDIC_ITERS - 1)) state_next = B_ACC;
      B_ACC:   state_next = cur.last ? B_TAIL : B_IDLE;
      B_TAIL: begin
        if (!enable || cur_cnt < CW'(2) || broken || scored_count == 16'd0) begin
          state_next = B_EMIT;
        end else begin
          state_next = B_DIV;
        end
      end
      B_DIV:    if (div_cnt == 5'd31) state_next = B_WEIGHT;
      B_WEIGHT: state_next = B_POW;
      B_POW:    if (pk >= pexp) state_next = B_EMIT;
      B_EMIT:   state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // ---- outputs ----
  always_comb begin
    q_pop = (state == B_IDLE) && !q_empty;
    done  = (state == B_EMIT);
    unique case (state)
      B_RD_B:  rd_addr = b_idx;
      B_RD_E:  rd_addr = e_idx;
      default: rd_addr = scan_i[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // path store
  always_ff @(posedge clk) begin
    if (state == B_DISP && !cur.is_sample && cur.store_ok) begin
      mem_x[cur_cnt[AW-1:0]] <= cur.pos_x;
      mem_y[cur_cnt[AW-1:0]] <= cur.pos_y;
      mem_h[cur_cnt[AW-1:0]] <= cur.heading;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
    rd_h <= mem_h[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      broken       <= 1'b0;
      cost_sum     <= 32'd0;
      scored_count <= 16'd0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      if (state == B_DISP && cur.is_sample && cur.scored && !broken && cur.invalid) begin
        broken <= 1'b1;
      end
      if (state == B_ACC) begin
        cost_sum <= sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
        if (scored_count < 16'(MAX_TIME_STEPS)) begin
          scored_count <= scored_count + 16'd1;
        end
      end
      if (state == B_EMIT) begin
        broken       <= 1'b0;
        cost_sum     <= 32'd0;
        scored_count <= 16'd0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= item;
      cur_cnt <= item_cnt;
    end
    idx1 <= scan_i[AW-1:0];
    idx2 <= idx1;
    idx3 <= idx2;
    ax   <= abs_x;
    ay   <= abs_y;
    sqx  <= ax * ax;
    sqy  <= ay * ay;
    if (v3 && (idx3 == '0 || dist_sum < best_d)) begin
      best_idx <= idx3;
      best_d   <= dist_sum;
    end
    unique case (state)
      B_DISP: scan_i <= '0;
      B_SCAN: if (issue) scan_i <= scan_i + CW'(1);
      B_RD_E: begin
        bx <= rd_x;
        by <= rd_y;
        bh <= rd_h;
      end
      B_SEG: begin
        vx <= 44'(seg_dx);
        vy <= 44'(seg_dy);
        z  <= mid ? bh : rd_h;
      end
      B_NORM: begin
        iter <= 4'd0;
        if (vx_small && vy_small) begin
          vx <= vx <<< 1;
          vy <= vy <<< 1;
        end else if (vx < 44'sd0) begin
          vx <= -vx;
          vy <= -vy;
          z  <= 16'd32768;
        end else begin
          z  <= 16'd0;
        end
      end
      B_VEC: begin
        iter <= iter + 4'd1;
        if (vy >= 44'sd0) begin
          vx <= vx + shvy;
          vy <= vy - shvx;
          z  <= z + tab;
        end else begin
          vx <= vx - shvy;
          vy <= vy + shvx;
          z  <= z - tab;
        end
      end
      B_CINIT: begin
        iter <= 4'd0;
        cx   <= CORDIC_GAIN_INV;
        cy   <= 34'sd0;
        if (err >= 16'd16384 && err < 16'd49152) begin
          cr   <= $signed({2'b00, err}) - 18'sd32768;
          cneg <= 1'b1;
        end else if (err >= 16'd49152) begin
          cr   <= $signed({2'b00, err}) - 18'sd65536;
          cneg <= 1'b0;
        end else begin
          cr   <= $signed({2'b00, err});
          cneg <= 1'b0;
        end
      end
      B_COS: begin
        iter <= iter + 4'd1;
        if (cr >= 18'sd0) begin
          cx <= cx - shcy;
          cy <= cy + shcx;
          cr <= cr - $signed({2'b00, tab});
        end else begin
          cx <= cx + shcy;
          cy <= cy - shcx;
          cr <= cr + $signed({2'b00, tab});
        end
      end
      B_TAIL: begin
        div_rem <= 16'd0;
        div_q   <= cost_sum;
        div_cnt <= 5'd0;
        path_too_short <= 1'b0;
        if (!enable) begin
          trajectory_cost <= 32'd0;
        end else if (cur_cnt < CW'(2)) begin
          trajectory_cost <= invalid_penalty;
          path_too_short  <= 1'b1;
        end else if (broken) begin
          trajectory_cost <= invalid_penalty;
        end else begin
          trajectory_cost <= 32'd0;
        end
      end
      B_DIV: begin
        div_cnt <= div_cnt + 5'd1;
        div_rem <= rem_ge ? 16'(rem_sh - {1'b0, scored_count}) : rem_sh[15:0];
        div_q   <= {div_q[30:0], rem_ge};
      end
      B_WEIGHT: begin
        base <= base_sat;
        acc  <= base_sat;
        pk   <= 3'd1;
      end
      B_POW: begin
        if (pk < pexp) begin
          acc <= pow_sat;
          pk  <= pk + 3'd1;
        end else begin
          trajectory_cost <= acc;
        end
      end
      default: begin
      end
    endcase
  end

  a_scan_not_broken: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN) |-> !broken)
    else $error("scan running on a broken trajectory");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    scored_count <= 16'(MAX_TIME_STEPS))
    else $error("scored count beyond limit");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == B_EMIT) |=> (cost_sum == 32'd0 && scored_count == 16'd0 && !broken))
    else $error("accumulators not cleared after result");

  a_pop_dispatch: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == B_DISP))
    else $error("popped item not dispatched");

endmodule

>>> src/path_heading_cost.sv
// path_heading_cost: heading alignment cost of trajectories against a path
//
// input channel: an item is taken at a rising edge with start high and busy
//   low; action 0 loads one path point, action 1 is one trajectory sample
// result channel: done is high for exactly one cycle with trajectory_cost
//   and path_too_short valid; the receiver cannot hold results off
// config: cfg_we writes cfg_data into register cfg_index at once
//   (0 enable, 1 mean_weight, 2 cost_exponent, 3 sample_stride,
//   4 invalid_penalty); write only while the block is idle
// the front classifies items into a two-entry queue; busy means it is full
// back end work: a path load or an unscored sample passes only the pop and
//   dispatch states; a scored sample runs the one-point-a-cycle nearest point
//   scan over all stored points, the normalize shifts and the two 16-step
//   cordic loops; a zero-length segment skips normalize and the vectoring loop
// result: follows the last sample's work, the 32-step mean divider and up to
//   six power multiplies; divider and multiplies are skipped when disabled,
//   the path is short, the trajectory is broken or nothing scored
// reset: clears the path count, accumulators and queue; path memory is
//   left as is and must be loaded before samples are scored
module path_heading_cost #(
  parameter int MAX_PATH_POINTS = 256,
  parameter int MAX_TIME_STEPS = 65535
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic               first_point,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [15:0]        heading,
  input  logic               sample_invalid,
  input  logic               last_sample,
  output logic               done,
  output logic [31:0]        trajectory_cost,
  output logic               path_too_short,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import phc_pkg::*;

  localparam int CW = $clog2(MAX_PATH_POINTS + 1);
  localparam int QW = $bits(phc_item_t) + CW;

  // configuration registers
  logic        enable;
  logic [15:0] mean_weight;
  logic [2:0]  cost_exponent;
  logic [7:0]  sample_stride;
  logic [31:0] invalid_penalty;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b1;
      mean_weight     <= 16'd256;
      cost_exponent   <= 3'd1;
      sample_stride   <= 8'd1;
      invalid_penalty <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (phc_reg_t'(cfg_index))
        REG_ENABLE:   enable          <= cfg_data[0];
        REG_WEIGHT:   mean_weight     <= cfg_data[15:0];
        REG_EXPONENT: cost_exponent   <= cfg_data[2:0];
        REG_STRIDE:   sample_stride   <= cfg_data[7:0];
        REG_PENALTY:  invalid_penalty <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front to queue
  logic          push;
  phc_item_t     f_item;
  logic [CW-1:0] f_cnt;
  logic          q_full, q_empty, q_pop;
  logic [QW-1:0] q_rdata;
  phc_item_t     b_item;
  logic [CW-1:0] b_cnt;

  assign busy = q_full;
  assign {b_cnt, b_item} = q_rdata;

  phc_front #(
    .MAX_PATH_POINTS(MAX_PATH_POINTS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .q_full         (q_full),
    .action         (action),
    .first_point    (first_point),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .heading        (heading),
    .sample_invalid (sample_invalid),
    .last_sample    (last_sample),
    .enable         (enable),
    .sample_stride  (sample_stride),
    .push           (push),
    .item           (f_item),
    .item_cnt       (f_cnt)
  );

  // short queue decouples the item front from the scoring engine
  phc_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({f_cnt, f_item}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  phc_back #(
    .MAX_PATH_POINTS(MAX_PATH_POINTS),
    .MAX_TIME_STEPS (MAX_TIME_STEPS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .item            (b_item),
    .item_cnt        (b_cnt),
    .enable          (enable),
    .mean_weight     (mean_weight),
    .cost_exponent   (cost_exponent),
    .invalid_penalty (invalid_penalty),
    .done            (done),
    .trajectory_cost (trajectory_cost),
    .path_too_short  (path_too_short)
  );

endmodule
